@@ hw/rtl/tcps_pkg.sv @@
package tcps_pkg;

  // Largest cell edge honored; larger register values saturate to this.
  localparam int unsigned MAX_CELL_SIZE = 64;
  localparam int unsigned SIZE_W        = 7;

  localparam logic [SIZE_W-1:0] CELL_WIDTH_RESET  = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] CELL_HEIGHT_RESET = SIZE_W'(16);

  typedef enum logic {
    REG_CELL_WIDTH  = 1'b0,
    REG_CELL_HEIGHT = 1'b1
  } reg_index_t;

  // Character code ranges of the procedural glyphs.
  localparam logic [7:0] CODE_QUAD_LO  = 8'h80;
  localparam logic [7:0] CODE_QUAD_HI  = 8'h8F;
  localparam logic [7:0] CODE_SHADE_LO = 8'h90;
  localparam logic [7:0] CODE_SHADE_HI = 8'h93;
  localparam logic [7:0] CODE_TRACE_LO = 8'hA0;
  localparam logic [7:0] CODE_TRACE_HI = 8'hA7;

  // At or above this alpha a shade is drawn as plain foreground.
  localparam logic [7:0] ALPHA_OPAQUE = 8'd252;
  localparam logic [7:0] WEIGHT_FULL  = 8'd255;
  localparam logic [7:0] MIX_ROUND    = 8'd128;

  localparam logic [4:0] RB_MAX = 5'h1F;
  localparam logic [5:0] G_MAX  = 6'h3F;

  typedef enum logic [1:0] {
    PICK_BG,
    PICK_FG,
    PICK_MIX
  } pick_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [5:0]  pix_x;
    logic [5:0]  pix_y;
    logic [3:0]  coverage;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic        block_glyph;
  } pix_out_t;

  // Decode stage result: which color to take and the blend weight.
  typedef struct packed {
    pick_t       pick;
    logic [7:0]  weight;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic        block_glyph;
  } dec_t;

  // Multiply stage result: weighted channel products.
  typedef struct packed {
    pick_t       pick;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic        block_glyph;
    logic [12:0] r_fg;
    logic [12:0] r_bg;
    logic [13:0] g_fg;
    logic [13:0] g_bg;
    logic [12:0] b_fg;
    logic [12:0] b_bg;
  } prod_t;

  // Blend weights of the four shade codes.
  function automatic logic [7:0] shade_weight(input logic [1:0] level);
    logic [7:0] w;
    case (level)
      2'd0:    w = 8'd64;
      2'd1:    w = 8'd128;
      2'd2:    w = 8'd191;
      default: w = 8'd255;
    endcase
    return w;
  endfunction

  // Perceptual coverage ramp: a = cov*17, lin = (a*a+127)/255, w = (a+lin)/2.
  function automatic logic [7:0] ramp_weight(input logic [3:0] cov);
    logic [7:0] w;
    case (cov)
      4'd1:    w = 8'd9;
      4'd2:    w = 8'd19;
      4'd3:    w = 8'd30;
      4'd4:    w = 8'd43;
      4'd5:    w = 8'd56;
      4'd6:    w = 8'd71;
      4'd7:    w = 8'd87;
      4'd8:    w = 8'd104;
      4'd9:    w = 8'd122;
      4'd10:   w = 8'd141;
      4'd11:   w = 8'd162;
      4'd12:   w = 8'd183;
      4'd13:   w = 8'd206;
      4'd14:   w = 8'd230;
      4'd15:   w = 8'd255;
      default: w = 8'd0;
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/tcps_decode.sv @@
module tcps_decode (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [tcps_pkg::SIZE_W-1:0]     cell_w,
  input  logic [tcps_pkg::SIZE_W-1:0]     cell_h,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tcps_pkg::pix_in_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tcps_pkg::dec_t                  out_data
);
  import tcps_pkg::*;

  logic [9:0]        trace_prod;
  logic [SIZE_W-1:0] trace_h;
  logic signed [8:0] cx;
  logic signed [8:0] px_s;
  logic signed [8:0] py_s;
  logic signed [8:0] ch_s;
  logic signed [8:0] top_s;
  logic              trace_on;
  logic              qx;
  logic              qy;
  logic              quad_on;
  logic [7:0]        shade_w;
  dec_t              dec;

  always_comb begin
    // Trace height: cell_h * eighths / 8, never below one row.
    trace_prod = 10'(cell_h) * 10'({1'b0, in_data.char_code[2:0]} + 4'd1);
    trace_h    = (trace_prod[9:3] == '0) ? SIZE_W'(1) : trace_prod[9:3];
    cx         = $signed({3'b0, cell_w[SIZE_W-1:1]}) - 9'sd1;
    px_s       = $signed({3'b0, in_data.pix_x});
    py_s       = $signed({3'b0, in_data.pix_y});
    ch_s       = $signed({2'b0, cell_h});
    top_s      = ch_s - $signed({2'b0, trace_h});
    trace_on   = (px_s >= cx) && (px_s < cx + 9'sd2) && (py_s >= top_s) && (py_s < ch_s);

    qx      = {1'b0, in_data.pix_x} >= {1'b0, cell_w[SIZE_W-1:1]};
    qy      = {1'b0, in_data.pix_y} >= {1'b0, cell_h[SIZE_W-1:1]};
    quad_on = in_data.char_code[{qy, qx}];

    shade_w = shade_weight(in_data.char_code[1:0]);

    dec.fg_color    = in_data.fg_color;
    dec.bg_color    = in_data.bg_color;
    dec.block_glyph = 1'b1;
    dec.weight      = ramp_weight(in_data.coverage);
    dec.pick        = PICK_MIX;

    if (in_data.char_code >= CODE_TRACE_LO && in_data.char_code <= CODE_TRACE_HI) begin
      dec.pick = trace_on ? PICK_FG : PICK_BG;
    end else if (in_data.char_code >= CODE_SHADE_LO &&
                 in_data.char_code <= CODE_SHADE_HI) begin
      dec.weight = shade_w;
      dec.pick   = (shade_w >= ALPHA_OPAQUE) ? PICK_FG : PICK_MIX;
    end else if (in_data.char_code >= CODE_QUAD_LO &&
                 in_data.char_code <= CODE_QUAD_HI) begin
      dec.pick = quad_on ? PICK_FG : PICK_BG;
    end else begin
      dec.block_glyph = 1'b0;
      dec.pick        = (in_data.coverage == '0) ? PICK_BG : PICK_MIX;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= dec;
    end
  end

endmodule

@@ hw/rtl/tcps_mult.sv @@
module tcps_mult (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcps_pkg::dec_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tcps_pkg::prod_t out_data
);
  import tcps_pkg::*;

  logic [7:0] w_inv;
  prod_t      prod;

  always_comb begin
    w_inv            = WEIGHT_FULL - in_data.weight;
    prod.pick        = in_data.pick;
    prod.fg_color    = in_data.fg_color;
    prod.bg_color    = in_data.bg_color;
    prod.block_glyph = in_data.block_glyph;
    prod.r_fg = 13'(in_data.fg_color[15:11]) * 13'(in_data.weight);
    prod.r_bg = 13'(in_data.bg_color[15:11]) * 13'(w_inv);
    prod.g_fg = 14'(in_data.fg_color[10:5]) * 14'(in_data.weight);
    prod.g_bg = 14'(in_data.bg_color[10:5]) * 14'(w_inv);
    prod.b_fg = 13'(in_data.fg_color[4:0]) * 13'(in_data.weight);
    prod.b_bg = 13'(in_data.bg_color[4:0]) * 13'(w_inv);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= prod;
    end
  end

endmodule

@@ hw/rtl/tcps_pack.sv @@
module tcps_pack (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcps_pkg::prod_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcps_pkg::pix_out_t out_data
);
  import tcps_pkg::*;

  logic [13:0] r_sum;
  logic [14:0] g_sum;
  logic [13:0] b_sum;
  logic [4:0]  r_ch;
  logic [5:0]  g_ch;
  logic [4:0]  b_ch;
  pix_out_t    res;

  always_comb begin
    r_sum = 14'(in_data.r_fg) + 14'(in_data.r_bg) + 14'(MIX_ROUND);
    g_sum = 15'(in_data.g_fg) + 15'(in_data.g_bg) + 15'(MIX_ROUND);
    b_sum = 14'(in_data.b_fg) + 14'(in_data.b_bg) + 14'(MIX_ROUND);
    r_ch  = (r_sum[13:8] > 6'(RB_MAX)) ? RB_MAX : r_sum[12:8];
    g_ch  = (g_sum[14:8] > 7'(G_MAX))  ? G_MAX  : g_sum[13:8];
    b_ch  = (b_sum[13:8] > 6'(RB_MAX)) ? RB_MAX : b_sum[12:8];

    res.block_glyph = in_data.block_glyph;
    case (in_data.pick)
      PICK_FG:  res.pixel_color = in_data.fg_color;
      PICK_MIX: res.pixel_color = {r_ch, g_ch, b_ch};
      default:  res.pixel_color = in_data.bg_color;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res;
    end
  end

endmodule

@@ hw/rtl/text_cell_pixel_shader.sv @@
// Text cell pixel shader: for each pixel of a character cell it turns the
// character code, the RGB565 foreground and background colors, the pixel's
// position in the cell and the glyph coverage nibble into one RGB565 color.
// Codes 0x80-0x8F draw quadrant blocks, 0x90-0x93 flat shades blended at
// alpha 64, 128, 191 and 255, 0xA0-0xA7 a two-pixel-wide centered trace of
// one to eight eighths of the cell height, and every other code goes through
// a perceptual coverage ramp, where zero coverage gives the background.
// block_glyph marks the procedurally drawn codes. The block takes one pixel
// per clock while no stage stalls; each result passes its register stages
// in order: one decodes the code and picks the blend weight, one holds the
// six per-channel products, one rounds, clamps and packs the color. Each
// stage stalls only when the stage after it is full, so a result waiting on
// shade_ready does not stop the input while an empty stage remains. Cell width
// and height must be written through the cfg port only while no pixels are
// in flight, which the block does not enforce; values above 64 act as 64.
module text_cell_pixel_shader (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  tcps_pkg::reg_index_t        cfg_index,
  input  logic [tcps_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic                        pix_valid,
  output logic                        pix_ready,
  input  tcps_pkg::pix_in_t           pix_data,
  output logic                        shade_valid,
  input  logic                        shade_ready,
  output tcps_pkg::pix_out_t          shade_data
);
  import tcps_pkg::*;

  logic [SIZE_W-1:0] cell_width;
  logic [SIZE_W-1:0] cell_height;
  logic [SIZE_W-1:0] cell_w;
  logic [SIZE_W-1:0] cell_h;

  logic  dec_valid;
  logic  dec_ready;
  dec_t  dec_data;
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod_data;

  // Configuration registers, written with no handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width  <= CELL_WIDTH_RESET;
      cell_height <= CELL_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_WIDTH:  cell_width  <= cfg_wdata;
        REG_CELL_HEIGHT: cell_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective cell size, saturated to the largest supported cell.
  assign cell_w = ({2'b0, cell_width} > 9'(MAX_CELL_SIZE)) ?
                  SIZE_W'(MAX_CELL_SIZE) : cell_width;
  assign cell_h = ({2'b0, cell_height} > 9'(MAX_CELL_SIZE)) ?
                  SIZE_W'(MAX_CELL_SIZE) : cell_height;

  tcps_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cell_w    (cell_w),
    .cell_h    (cell_h),
    .in_valid  (pix_valid),
    .in_ready  (pix_ready),
    .in_data   (pix_data),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  tcps_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  // The last stage is the output register seen on the shade port.
  tcps_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (shade_valid),
    .out_ready (shade_ready),
    .out_data  (shade_data)
  );

endmodule

@@ hw/rtl/tcps_checker.sv @@
module tcps_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_we,
  input tcps_pkg::reg_index_t        cfg_index,
  input logic [tcps_pkg::SIZE_W-1:0] cfg_wdata,
  input logic                        pix_valid,
  input logic                        pix_ready,
  input tcps_pkg::pix_in_t           pix_data,
  input logic                        shade_valid,
  input logic                        shade_ready,
  input tcps_pkg::pix_out_t          shade_data
);
  import tcps_pkg::*;

  // No result may appear in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !shade_valid)
    else $error("result valid right after reset");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    shade_valid && !shade_ready |=> shade_valid && $stable(shade_data))
    else $error("stalled result changed or dropped");

  // With the output draining, a transfer in reaches the output through the decode, multiply and pack registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_ready) ##1 shade_ready ##1 shade_ready |=> shade_valid)
    else $error("accepted pixel did not reach the output in time");

  // A draining output or an empty output register leaves the input open.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    shade_ready || !shade_valid |-> pix_ready)
    else $error("input stalled while the output could move");

endmodule

bind text_cell_pixel_shader tcps_checker u_tcps_checker (.*);

@@ tb/text_cell_pixel_shader_tb.sv @@
`timescale 1ns / 1ps

// Self-checking testbench for the text cell pixel shader.
//
// An initial block runs the whole test. It steps through a list of cell
// geometries and fills a queue with pixels for each one: random pixels,
// after a short directed set for the first. A driver on the falling clock
// edge feeds that queue into the pixel input, and a monitor on the rising
// clock edge watches both channels. Every input transfer is run through a
// local model of the shader, and the predicted color is queued. Every output
// transfer is checked against the oldest prediction.
module text_cell_pixel_shader_tb;
  import tcps_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int RESET_LEN   = 7;
  localparam int LATENCY     = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_GEOMS   = 8;
  localparam int PIX_PER_GEO = 170;

  // Cell geometries. The first one keeps the reset values and is never
  // written. The others cover the smallest sizes, the largest honored size,
  // values that saturate, and the degenerate sizes zero and one.
  localparam int GEO_W [NUM_GEOMS] = '{8, 2, 64, 127, 0, 65, 7, 33};
  localparam int GEO_H [NUM_GEOMS] = '{16, 2, 64, 127, 1, 3, 13, 64};

  // Alpha of the four shade codes, in code order.
  localparam int SHADE_ALPHA [4] = '{64, 128, 191, 255};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  reg_index_t           cfg_index = REG_CELL_WIDTH;
  logic [SIZE_W-1:0]    cfg_wdata = '0;
  logic                 pix_valid = 1'b0;
  logic                 pix_ready;
  pix_in_t              pix_data = '0;
  logic                 shade_valid;
  logic                 shade_ready = 1'b0;
  pix_out_t             shade_data;

  // Pixels waiting to be driven, and colors the shader still owes us.
  pix_in_t              pixel_feed[$];
  pix_out_t             owed_colors[$];

  // Local copy of the two size registers, updated when a write lands.
  logic [SIZE_W-1:0]    width_reg;
  logic [SIZE_W-1:0]    height_reg;

  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   err_cnt = 0;
  int                   pix_in_cnt = 0;
  int                   pix_out_cnt = 0;
  int                   cycle_cnt = 0;
  bit                   in_taken = 1'b0;
  bit                   drv_valid;

  text_cell_pixel_shader DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .pix_data    (pix_data),
    .shade_valid (shade_valid),
    .shade_ready (shade_ready),
    .shade_data  (shade_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Register values above the largest cell size act as the largest size.
  function automatic int cell_extent(int reg_val);
    return (reg_val > int'(MAX_CELL_SIZE)) ? int'(MAX_CELL_SIZE) : reg_val;
  endfunction

  // One channel of a weighted mix, rounded and clamped to the channel range.
  function automatic int mix_channel(int f, int b, int w, int maxv);
    int v;
    v = (f * w + b * (255 - w) + 128) >> 8;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic logic [15:0] mix_rgb565(logic [15:0] fg, logic [15:0] bg, int w);
    int r;
    int g;
    int b;
    r = mix_channel(int'(fg[15:11]), int'(bg[15:11]), w, int'(RB_MAX));
    g = mix_channel(int'(fg[10:5]), int'(bg[10:5]), w, int'(G_MAX));
    b = mix_channel(int'(fg[4:0]), int'(bg[4:0]), w, int'(RB_MAX));
    return 16'((r << 11) | (g << 5) | b);
  endfunction

  // Predicts the shader's output for one pixel under the given registers.
  function automatic pix_out_t shade_pixel(pix_in_t p, logic [SIZE_W-1:0] w_reg,
                                           logic [SIZE_W-1:0] h_reg);
    pix_out_t res;
    int cw;
    int ch;
    int px;
    int py;
    int h;
    int cx;
    int alpha;
    int a;
    int lin;
    int qx;
    int qy;
    cw = cell_extent(int'(w_reg));
    ch = cell_extent(int'(h_reg));
    px = int'(p.pix_x);
    py = int'(p.pix_y);
    res.block_glyph = 1'b1;
    if (p.char_code >= CODE_TRACE_LO && p.char_code <= CODE_TRACE_HI) begin
      // Centered two-pixel trace rising from the bottom of the cell; it is
      // always at least one row tall.
      h = ch * (int'(p.char_code - CODE_TRACE_LO) + 1) / 8;
      if (h < 1) h = 1;
      cx = cw / 2 - 1;
      if (px >= cx && px < cx + 2 && py >= ch - h && py < ch) begin
        res.pixel_color = p.fg_color;
      end else begin
        res.pixel_color = p.bg_color;
      end
    end else if (p.char_code >= CODE_SHADE_LO && p.char_code <= CODE_SHADE_HI) begin
      alpha = SHADE_ALPHA[int'(p.char_code - CODE_SHADE_LO)];
      if (alpha == 0) begin
        res.pixel_color = p.bg_color;
      end else if (alpha >= int'(ALPHA_OPAQUE)) begin
        res.pixel_color = p.fg_color;
      end else begin
        res.pixel_color = mix_rgb565(p.fg_color, p.bg_color, alpha);
      end
    end else if (p.char_code >= CODE_QUAD_LO && p.char_code <= CODE_QUAD_HI) begin
      // Low four code bits light the quadrants: top-left, top-right,
      // bottom-left, bottom-right.
      qx = (px >= cw / 2) ? 1 : 0;
      qy = (py >= ch / 2) ? 1 : 0;
      res.pixel_color = p.char_code[qy * 2 + qx] ? p.fg_color : p.bg_color;
    end else begin
      // Ordinary glyph, including the unused codes just above the shades:
      // the coverage nibble goes through a perceptual ramp.
      res.block_glyph = 1'b0;
      if (p.coverage == 4'd0) begin
        res.pixel_color = p.bg_color;
      end else begin
        a = int'(p.coverage) * 17;
        lin = (a * a + 127) / 255;
        res.pixel_color = mix_rgb565(p.fg_color, p.bg_color, (a + lin) / 2);
      end
    end
    return res;
  endfunction

  function automatic pix_in_t make_pixel(logic [7:0] code, logic [15:0] fg, logic [15:0] bg,
                                         logic [5:0] x, logic [5:0] y, logic [3:0] cov);
    pix_in_t p;
    p.char_code = code;
    p.fg_color  = fg;
    p.bg_color  = bg;
    p.pix_x     = x;
    p.pix_y     = y;
    p.coverage  = cov;
    return p;
  endfunction

  // Random pixel for a cell of cw by ch. Most positions fall inside the cell,
  // and trace codes often land on the two center columns so that the trace
  // edges are actually exercised.
  function automatic pix_in_t random_pixel(int cw, int ch);
    pix_in_t p;
    int pick;
    int x;
    pick = $urandom_range(99);
    if (pick < 25) begin
      p.char_code = CODE_QUAD_LO + 8'($urandom_range(15));
    end else if (pick < 40) begin
      p.char_code = CODE_SHADE_LO + 8'($urandom_range(3));
    end else if (pick < 60) begin
      p.char_code = CODE_TRACE_LO + 8'($urandom_range(7));
    end else if (pick < 70) begin
      p.char_code = 8'($urandom_range(8'h9F, 8'h94));
    end else begin
      p.char_code = 8'($urandom);
    end
    p.fg_color = 16'($urandom);
    p.bg_color = 16'($urandom);
    if (p.char_code >= CODE_TRACE_LO && p.char_code <= CODE_TRACE_HI &&
        $urandom_range(1) == 1) begin
      x = cw / 2 - 1 + int'($urandom_range(1));
      p.pix_x = (x < 0) ? 6'd0 : 6'(x);
    end else if (cw > 0 && $urandom_range(99) < 85) begin
      p.pix_x = 6'($urandom_range(cw - 1, 0));
    end else begin
      p.pix_x = 6'($urandom);
    end
    if (ch > 0 && $urandom_range(99) < 85) begin
      p.pix_y = 6'($urandom_range(ch - 1, 0));
    end else begin
      p.pix_y = 6'($urandom);
    end
    p.coverage = ($urandom_range(9) == 0) ? 4'd0 : 4'($urandom);
    return p;
  endfunction

  // Holds off until every queued pixel has been sent and every color has come
  // back. Checked shortly after the falling edge, once the driver's updates
  // of that edge have landed.
  task automatic wait_drained();
    @(negedge clk);
    #1;
    while (pixel_feed.size() != 0 || pix_valid || owed_colors.size() != 0) begin
      @(negedge clk);
      #1;
    end
  endtask

  // Writes both size registers, one per cycle. Only called while drained.
  task automatic write_geometry(int w, int h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CELL_WIDTH;
    cfg_wdata <= SIZE_W'(w);
    @(negedge clk);
    cfg_index <= REG_CELL_HEIGHT;
    cfg_wdata <= SIZE_W'(h);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Driver. A pending pixel is held until its transfer; after that the next
  // one is offered at once unless the sender chooses to idle this cycle.
  always @(negedge clk) begin
    if (rst) begin
      pix_valid   <= 1'b0;
      shade_ready <= 1'b0;
    end else begin
      drv_valid = pix_valid && !in_taken;
      if (!drv_valid && pixel_feed.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        pix_data <= pixel_feed.pop_front();
        drv_valid = 1'b1;
      end
      pix_valid   <= drv_valid;
      shade_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor. Register writes update the local copy; each input transfer adds
  // a prediction; each output transfer is checked against the oldest one.
  always @(posedge clk) begin
    pix_out_t want;
    in_taken = 1'b0;
    if (rst) begin
      width_reg  = CELL_WIDTH_RESET;
      height_reg = CELL_HEIGHT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CELL_WIDTH:  width_reg = cfg_wdata;
          REG_CELL_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (pix_valid && pix_ready) begin
        in_taken = 1'b1;
        owed_colors.push_back(shade_pixel(pix_data, width_reg, height_reg));
        pix_in_cnt++;
      end
      if (shade_valid && shade_ready) begin
        pix_out_cnt++;
        if (owed_colors.size() == 0) begin
          $error("unexpected output transfer: pixel_color %h block_glyph %b",
                 shade_data.pixel_color, shade_data.block_glyph);
          err_cnt++;
        end else begin
          want = owed_colors.pop_front();
          if (shade_data.pixel_color !== want.pixel_color) begin
            $error("pixel_color: expected %h, actual %h",
                   want.pixel_color, shade_data.pixel_color);
            err_cnt++;
          end
          if (shade_data.block_glyph !== want.block_glyph) begin
            $error("block_glyph: expected %b, actual %b",
                   want.block_glyph, shade_data.block_glyph);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int cw;
    int ch;
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int geo = 0; geo < NUM_GEOMS; geo++) begin
      wait_drained();
      // Idle pattern: sender light and receiver heavy, then the reverse,
      // then full rate on both sides.
      if (geo < 3) begin
        send_idle_pct = 14;
        recv_idle_pct = 47;
      end else if (geo < 6) begin
        send_idle_pct = 47;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (geo != 0) write_geometry(GEO_W[geo], GEO_H[geo]);
      cw = cell_extent(GEO_W[geo]);
      ch = cell_extent(GEO_H[geo]);

      if (geo == 0) begin
        // Directed pixels for the default 8x16 cell: ramp ends, zero
        // coverage, all quadrant corners, every shade, trace edges, the
        // unused codes above the shades and field extremes.
        pixel_feed.push_back(make_pixel(8'h41, 16'hFFFF, 16'h0000, 6'd0, 6'd0, 4'd0));
        pixel_feed.push_back(make_pixel(8'h41, 16'hFFFF, 16'h0000, 6'd63, 6'd63, 4'd15));
        pixel_feed.push_back(make_pixel(8'h00, 16'hF800, 16'h07FF, 6'd3, 6'd5, 4'd8));
        pixel_feed.push_back(make_pixel(8'hFF, 16'h0000, 16'hFFFF, 6'd1, 6'd2, 4'd1));
        pixel_feed.push_back(make_pixel(CODE_QUAD_LO, 16'hFFFF, 16'h0000, 6'd0, 6'd0, 4'd5));
        pixel_feed.push_back(make_pixel(CODE_QUAD_HI, 16'hFFFF, 16'h0000, 6'd7, 6'd15, 4'd0));
        pixel_feed.push_back(make_pixel(8'h85, 16'h1234, 16'hABCD, 6'd4, 6'd0, 4'd3));
        pixel_feed.push_back(make_pixel(8'h8A, 16'h1234, 16'hABCD, 6'd3, 6'd8, 4'd3));
        pixel_feed.push_back(make_pixel(8'h86, 16'h1234, 16'hABCD, 6'd63, 6'd63, 4'd3));
        for (int s = 0; s < 4; s++) begin
          pixel_feed.push_back(make_pixel(CODE_SHADE_LO + 8'(s), 16'hFFFF, 16'h0000,
                                          6'd2, 6'd2, 4'd0));
          pixel_feed.push_back(make_pixel(CODE_SHADE_LO + 8'(s), 16'h1234, 16'hABCD,
                                          6'd5, 6'd9, 4'd15));
        end
        pixel_feed.push_back(make_pixel(CODE_TRACE_LO, 16'hFFFF, 16'h0000, 6'd3, 6'd15, 4'd0));
        pixel_feed.push_back(make_pixel(CODE_TRACE_LO, 16'hFFFF, 16'h0000, 6'd4, 6'd14, 4'd0));
        pixel_feed.push_back(make_pixel(CODE_TRACE_HI, 16'hFFFF, 16'h0000, 6'd3, 6'd0, 4'd0));
        pixel_feed.push_back(make_pixel(CODE_TRACE_HI, 16'hFFFF, 16'h0000, 6'd2, 6'd0, 4'd0));
        pixel_feed.push_back(make_pixel(8'hA3, 16'hFFFF, 16'h0000, 6'd63, 6'd63, 4'd9));
        pixel_feed.push_back(make_pixel(CODE_SHADE_HI + 8'd1, 16'h5555, 16'hAAAA,
                                        6'd4, 6'd4, 4'd10));
        pixel_feed.push_back(make_pixel(8'h9F, 16'hAAAA, 16'h5555, 6'd4, 6'd4, 4'd15));
        pixel_feed.push_back(make_pixel(8'hA8, 16'h07E0, 16'h001F, 6'd4, 6'd12, 4'd3));
      end

      // Random pixels in two halves, with a full drain between them so the
      // sender pauses until the shader has returned everything.
      for (int i = 0; i < PIX_PER_GEO / 2; i++) pixel_feed.push_back(random_pixel(cw, ch));
      wait_drained();
      for (int i = 0; i < PIX_PER_GEO / 2; i++) pixel_feed.push_back(random_pixel(cw, ch));
    end

    wait_drained();
    // Run on past the drain to catch any stray output after the last color.
    repeat (LATENCY * 4) @(posedge clk);
    @(negedge clk);
    if (owed_colors.size() != 0) begin
      $error("%0d predicted colors never arrived", owed_colors.size());
      err_cnt++;
    end

    $display("Shaded %0d pixels (%0d returned) across %0d cell geometries,",
             pix_in_cnt, pix_out_cnt, NUM_GEOMS);
    $display("with quadrant, shade, trace and coverage ramp codes; %0d mismatches.",
             err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
